[sv/lfs_pkg.sv]
// ----------------------------------------------------------------------------
// lfs_pkg
// Shared types, widths, register indexes and pattern classes for the
// line-follow steering unit.
// ----------------------------------------------------------------------------
package lfs_pkg;

    // Field widths
    localparam int PAT_W   = 5;
    localparam int POS_W   = 12;
    localparam int GAIN_W  = 16;
    localparam int SPEED_W = 8;
    localparam int FRAC_W  = 16;

    // Integral width (saturating accumulator)
    localparam int SUM_BITS = 24;

    // Derived datapath widths
    localparam int ERR_W  = POS_W + 1;
    localparam int DIF_W  = ERR_W + 1;
    localparam int PP_W   = ERR_W + GAIN_W + 1;
    localparam int PI_W   = SUM_BITS + GAIN_W + 1;
    localparam int PD_W   = DIF_W + GAIN_W + 1;
    localparam int ACC_W  = PI_W + 2;
    localparam int CORR_W = ACC_W - FRAC_W;
    localparam int SPD_W  = CORR_W + 2;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = GAIN_W;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SETPOINT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_SPEED_A = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_SPEED_B = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED_A  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED_B  = 3'd7;

    // Register reset values
    localparam logic [GAIN_W-1:0]  RST_GAIN_P   = 16'd4588;
    localparam logic [GAIN_W-1:0]  RST_GAIN_I   = 16'd52;
    localparam logic [GAIN_W-1:0]  RST_GAIN_D   = 16'd39322;
    localparam logic [POS_W-1:0]   RST_SETPOINT = 12'd2000;
    localparam logic [SPEED_W-1:0] RST_BASE     = 8'd100;
    localparam logic [SPEED_W-1:0] RST_MAX      = 8'd150;

    // Action codes
    typedef enum logic [1:0] {
        ACT_PID     = 2'd0,
        ACT_RIGHT   = 2'd1,
        ACT_LEFT    = 2'd2,
        ACT_FORWARD = 2'd3
    } action_t;

    // Configuration bundle
    typedef struct packed {
        logic [GAIN_W-1:0]  gain_p;
        logic [GAIN_W-1:0]  gain_i;
        logic [GAIN_W-1:0]  gain_d;
        logic [POS_W-1:0]   setpoint;
        logic [SPEED_W-1:0] base_speed_a;
        logic [SPEED_W-1:0] base_speed_b;
        logic [SPEED_W-1:0] max_speed_a;
        logic [SPEED_W-1:0] max_speed_b;
    } cfg_t;

    // Sensor pattern classes
    function automatic logic is_left_edge(input logic [PAT_W-1:0] p);
        return (p == 5'b11100) || (p == 5'b11000) || (p == 5'b10000);
    endfunction

    function automatic logic is_right_edge(input logic [PAT_W-1:0] p);
        return (p == 5'b00111) || (p == 5'b00011) || (p == 5'b00001);
    endfunction

    function automatic logic is_line_break(input logic [PAT_W-1:0] p);
        return (p == 5'b00100) || (p == 5'b00010) || (p == 5'b01000);
    endfunction

endpackage

[sv/lfs_cfg_regs.sv]
// ----------------------------------------------------------------------------
// lfs_cfg_regs
// Write-only configuration register file for the steering unit.
// ----------------------------------------------------------------------------
module lfs_cfg_regs
    import lfs_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write index into the register bundle
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                REG_GAIN_P:       cfg_next.gain_p       = cfg_wr_data;
                REG_GAIN_I:       cfg_next.gain_i       = cfg_wr_data;
                REG_GAIN_D:       cfg_next.gain_d       = cfg_wr_data;
                REG_SETPOINT:     cfg_next.setpoint     = cfg_wr_data[POS_W-1:0];
                REG_BASE_SPEED_A: cfg_next.base_speed_a = cfg_wr_data[SPEED_W-1:0];
                REG_BASE_SPEED_B: cfg_next.base_speed_b = cfg_wr_data[SPEED_W-1:0];
                REG_MAX_SPEED_A:  cfg_next.max_speed_a  = cfg_wr_data[SPEED_W-1:0];
                REG_MAX_SPEED_B:  cfg_next.max_speed_b  = cfg_wr_data[SPEED_W-1:0];
            endcase
        end
    end

    // Hold the register values, load defaults on reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gain_p       <= RST_GAIN_P;
            cfg_reg.gain_i       <= RST_GAIN_I;
            cfg_reg.gain_d       <= RST_GAIN_D;
            cfg_reg.setpoint     <= RST_SETPOINT;
            cfg_reg.base_speed_a <= RST_BASE;
            cfg_reg.base_speed_b <= RST_BASE;
            cfg_reg.max_speed_a  <= RST_MAX;
            cfg_reg.max_speed_b  <= RST_MAX;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[sv/line_follow_steering_unit.sv]
// ----------------------------------------------------------------------------
// line_follow_steering_unit
// Line follower steering: junction recovery from pattern history, else a
// Q16 PID step that drives two motors around their base speeds.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | contents
//  s_      | in        | s_tvalid/s_tready  | tdata: pattern, position
//  m_      | out       | m_tvalid/m_tready  | tuser: action; tdata: speed_a, speed_b
//  cfg_    | in        | cfg_wr_en          | cfg_wr_index, cfg_wr_data
//
// One transaction per cycle sustained while m_tready stays high; each
// result passes the input register, product register and output
// register. The gain multiplies sit between the first two registers.
// Reset is synchronous: history, integral and all valid flags clear.
// A stage advances when it is empty or the stage after it advances, so
// input is still taken while a result waits on m_tready until all three
// stages are full.
// ----------------------------------------------------------------------------
module line_follow_steering_unit
    import lfs_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // slave stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [23:0]           s_tdata,    // [4:0] pattern, [16:5] position
    // master stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,    // [7:0] speed_a, [15:8] speed_b
    output logic [1:0]            m_tuser,    // [1:0] action
    // configuration
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

    cfg_t cfg;

    lfs_cfg_regs u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .cfg          (cfg)
    );

    // ------------------------------------------------------------------
    // Pipeline control
    // ------------------------------------------------------------------
    logic v1_reg, v1_next;
    logic v2_reg, v2_next;
    logic v3_reg, v3_next;
    logic adv3, adv2, load1, fire1, fire2;

    assign adv3     = !v3_reg || m_tready;
    assign adv2     = !v2_reg || adv3;
    assign s_tready = !v1_reg || adv2;
    assign load1    = s_tvalid && s_tready;
    assign fire1    = v1_reg && adv2;
    assign fire2    = v2_reg && adv3;

    always_comb begin
        v1_next = v1_reg;
        v2_next = v2_reg;
        v3_next = v3_reg;
        if (s_tready) begin
            v1_next = s_tvalid;
        end
        if (adv2) begin
            v2_next = v1_reg;
        end
        if (adv3) begin
            v3_next = v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: input register
    // ------------------------------------------------------------------
    logic [PAT_W-1:0] pat_reg;
    logic [POS_W-1:0] pos_reg;

    always_ff @(posedge aclk) begin
        if (load1) begin
            pat_reg <= s_tdata[PAT_W-1:0];
            pos_reg <= s_tdata[PAT_W+POS_W-1:PAT_W];
        end
    end

    // ------------------------------------------------------------------
    // Stage 1 logic: recovery decision, error terms, integral, products
    // ------------------------------------------------------------------
    logic [PAT_W-1:0]           last_pattern_reg, last_pattern_next;
    logic [PAT_W-1:0]           prior_pattern_reg, prior_pattern_next;
    logic signed [SUM_BITS-1:0] error_sum_reg, error_sum_next;
    logic signed [ERR_W-1:0]    prev_error_reg, prev_error_next;

    localparam logic signed [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
    localparam logic signed [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};

    action_t                    act1;
    logic signed [ERR_W-1:0]    err1;
    logic signed [DIF_W-1:0]    dif1;
    logic signed [SUM_BITS:0]   sum_wide;
    logic signed [SUM_BITS-1:0] sum_sat;
    logic signed [PP_W-1:0]     prod_p1;
    logic signed [PI_W-1:0]     prod_i1;
    logic signed [PD_W-1:0]     prod_d1;

    // Pick the recovery action on an empty pattern
    always_comb begin
        act1 = ACT_PID;
        if (pat_reg == '0) begin
            priority if (is_left_edge(last_pattern_reg) || is_left_edge(prior_pattern_reg)) begin
                act1 = ACT_RIGHT;
            end else if (is_right_edge(last_pattern_reg)
                         || is_right_edge(prior_pattern_reg)) begin
                act1 = ACT_LEFT;
            end else if (is_line_break(last_pattern_reg)) begin
                act1 = ACT_FORWARD;
            end else begin
                act1 = ACT_PID;
            end
        end
    end

    // Form the error, its difference and the saturated integral
    always_comb begin
        err1     = $signed({1'b0, cfg.setpoint}) - $signed({1'b0, pos_reg});
        dif1     = {err1[ERR_W-1], err1} - {prev_error_reg[ERR_W-1], prev_error_reg};
        sum_wide = {error_sum_reg[SUM_BITS-1], error_sum_reg}
                 + {{(SUM_BITS+1-ERR_W){err1[ERR_W-1]}}, err1};
        if (sum_wide[SUM_BITS] != sum_wide[SUM_BITS-1]) begin
            sum_sat = sum_wide[SUM_BITS] ? SUM_MIN : SUM_MAX;
        end else begin
            sum_sat = sum_wide[SUM_BITS-1:0];
        end
    end

    // Multiply by the unsigned Q16 gains
    always_comb begin
        prod_p1 = err1    * $signed({1'b0, cfg.gain_p});
        prod_i1 = sum_sat * $signed({1'b0, cfg.gain_i});
        prod_d1 = dif1    * $signed({1'b0, cfg.gain_d});
    end

    // Shift the pattern history and update PID state on PID steps
    always_comb begin
        last_pattern_next  = last_pattern_reg;
        prior_pattern_next = prior_pattern_reg;
        error_sum_next     = error_sum_reg;
        prev_error_next    = prev_error_reg;
        if (fire1) begin
            prior_pattern_next = last_pattern_reg;
            last_pattern_next  = pat_reg;
            if (act1 == ACT_PID) begin
                error_sum_next  = sum_sat;
                prev_error_next = err1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_pattern_reg  <= '0;
            prior_pattern_reg <= '0;
            error_sum_reg     <= '0;
            prev_error_reg    <= '0;
        end else begin
            last_pattern_reg  <= last_pattern_next;
            prior_pattern_reg <= prior_pattern_next;
            error_sum_reg     <= error_sum_next;
            prev_error_reg    <= prev_error_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: product register
    // ------------------------------------------------------------------
    action_t                act2_reg;
    logic signed [PP_W-1:0] prod_p_reg;
    logic signed [PI_W-1:0] prod_i_reg;
    logic signed [PD_W-1:0] prod_d_reg;

    always_ff @(posedge aclk) begin
        if (fire1) begin
            act2_reg   <= act1;
            prod_p_reg <= prod_p1;
            prod_i_reg <= prod_i1;
            prod_d_reg <= prod_d1;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2 logic: sum, truncate toward zero, steer and clamp
    // ------------------------------------------------------------------
    logic signed [ACC_W-1:0]  acc2;
    logic signed [ACC_W-1:0]  acc_biased;
    logic signed [CORR_W-1:0] corr2;
    logic signed [SPD_W-1:0]  va, vb;
    logic [SPEED_W-1:0]       speed_a2, speed_b2;

    always_comb begin
        acc2 = {{(ACC_W-PP_W){prod_p_reg[PP_W-1]}}, prod_p_reg}
             + {{(ACC_W-PI_W){prod_i_reg[PI_W-1]}}, prod_i_reg}
             + {{(ACC_W-PD_W){prod_d_reg[PD_W-1]}}, prod_d_reg};
        // bias negative values so the shift rounds toward zero
        acc_biased = acc2 + (acc2[ACC_W-1] ? $signed({{(ACC_W-FRAC_W){1'b0}},
                                                      {FRAC_W{1'b1}}})
                                           : $signed({ACC_W{1'b0}}));
        corr2 = acc_biased[ACC_W-1:FRAC_W];
        va = $signed({{(SPD_W-SPEED_W){1'b0}}, cfg.base_speed_a})
           + {{(SPD_W-CORR_W){corr2[CORR_W-1]}}, corr2};
        vb = $signed({{(SPD_W-SPEED_W){1'b0}}, cfg.base_speed_b})
           - {{(SPD_W-CORR_W){corr2[CORR_W-1]}}, corr2};
    end

    // Zero both speeds on recovery actions; else clamp to the maximum first, then to zero
    always_comb begin
        priority if (act2_reg != ACT_PID) begin
            speed_a2 = '0;
        end else if (va > $signed({{(SPD_W-SPEED_W){1'b0}}, cfg.max_speed_a})) begin
            speed_a2 = cfg.max_speed_a;
        end else if (va[SPD_W-1]) begin
            speed_a2 = '0;
        end else begin
            speed_a2 = va[SPEED_W-1:0];
        end
        priority if (act2_reg != ACT_PID) begin
            speed_b2 = '0;
        end else if (vb > $signed({{(SPD_W-SPEED_W){1'b0}}, cfg.max_speed_b})) begin
            speed_b2 = cfg.max_speed_b;
        end else if (vb[SPD_W-1]) begin
            speed_b2 = '0;
        end else begin
            speed_b2 = vb[SPEED_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: output register
    // ------------------------------------------------------------------
    action_t            act3_reg;
    logic [SPEED_W-1:0] speed_a_reg;
    logic [SPEED_W-1:0] speed_b_reg;

    always_ff @(posedge aclk) begin
        if (fire2) begin
            act3_reg    <= act2_reg;
            speed_a_reg <= speed_a2;
            speed_b_reg <= speed_b2;
        end
    end

    assign m_tvalid = v3_reg;
    assign m_tdata  = {speed_b_reg, speed_a_reg};
    assign m_tuser  = act3_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // input stalls only when every stage is full and the output is blocked
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (v1_reg && v2_reg && v3_reg && !m_tready))
        else $error("input stalled with room in the pipeline");

    // recovery actions carry zero speeds
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser != ACT_PID)) |-> (m_tdata == '0))
        else $error("non-PID result with nonzero speed");

    // PID state moves only on a PID step leaving stage one
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(fire1 && (act1 == ACT_PID)) |=> ($stable(error_sum_reg) && $stable(prev_error_reg)))
        else $error("PID state changed without a PID step");

    // pattern history shifts whenever an item leaves stage one
    assert property (@(posedge aclk) disable iff (!aresetn)
        fire1 |=> (prior_pattern_reg == $past(last_pattern_reg)
                   && last_pattern_reg == $past(pat_reg)))
        else $error("pattern history did not shift");

endmodule

[test/lfs_steering_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfs_steering_checker
// Watches the sensor, steering and register ports of the line-follow
// steering unit. Tracks register writes, computes the steering command for
// every accepted sensor transaction and compares each steering transaction
// against the oldest command still waiting. Hands the failure count and the
// number of outstanding commands to the testbench top.
// ----------------------------------------------------------------------------
module lfs_steering_checker
    import lfs_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [23:0]           s_tdata,    // [4:0] pattern, [16:5] position
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [15:0]           m_tdata,    // [7:0] speed_a, [15:8] speed_b
    input  logic [1:0]            m_tuser,    // [1:0] action
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    output int                    fail_count,
    output int                    outstanding
);

    typedef struct packed {
        action_t            action;
        logic [SPEED_W-1:0] speed_a;
        logic [SPEED_W-1:0] speed_b;
    } steer_t;

    // Mirror of the register file and of the steering history
    cfg_t             regs;
    logic [PAT_W-1:0] hist_last;
    logic [PAT_W-1:0] hist_prior;
    longint           err_integral;
    longint           prev_err;
    int               errors;

    // Commands computed but not yet seen on the steering channel
    steer_t           pending_steer_q[$];

    function automatic logic left_pat(input logic [PAT_W-1:0] p);
        return p inside {5'b11100, 5'b11000, 5'b10000};
    endfunction

    function automatic logic right_pat(input logic [PAT_W-1:0] p);
        return p inside {5'b00111, 5'b00011, 5'b00001};
    endfunction

    function automatic logic gap_pat(input logic [PAT_W-1:0] p);
        return p inside {5'b00100, 5'b00010, 5'b01000};
    endfunction

    // Clamp to the motor maximum first, then to zero
    function automatic logic [SPEED_W-1:0] speed_clamp(input longint v,
                                                      input logic [SPEED_W-1:0] vmax);
        longint r;
        r = v;
        if (r > longint'(vmax)) r = longint'(vmax);
        if (r < 0) r = 0;
        return r[SPEED_W-1:0];
    endfunction

    // Steering command for one sensor sample; advances the history and PID state
    function automatic steer_t compute_steering(input logic [PAT_W-1:0] pat,
                                                input logic [POS_W-1:0] pos);
        steer_t r;
        longint sum_hi;
        longint sum_lo;
        longint err;
        longint dif;
        longint acc;
        longint corr;
        sum_hi = (longint'(1) << (SUM_BITS - 1)) - 1;
        sum_lo = -(longint'(1) << (SUM_BITS - 1));
        r.action  = ACT_PID;
        r.speed_a = '0;
        r.speed_b = '0;

        // Recover from a lost line using the two remembered patterns
        if (pat == '0) begin
            if (left_pat(hist_last) || left_pat(hist_prior)) begin
                r.action = ACT_RIGHT;
            end else if (right_pat(hist_last) || right_pat(hist_prior)) begin
                r.action = ACT_LEFT;
            end else if (gap_pat(hist_last)) begin
                r.action = ACT_FORWARD;
            end
        end

        if (r.action == ACT_PID) begin
            err = longint'(regs.setpoint) - longint'(pos);
            dif = err - prev_err;
            err_integral = err_integral + err;
            if (err_integral > sum_hi) err_integral = sum_hi;
            if (err_integral < sum_lo) err_integral = sum_lo;
            prev_err = err;

            acc = err * longint'(regs.gain_p)
                + err_integral * longint'(regs.gain_i)
                + dif * longint'(regs.gain_d);
            // Drop the fraction toward zero
            corr = ((acc < 0) ? -acc : acc) / (longint'(1) << FRAC_W);
            if (acc < 0) corr = -corr;

            r.speed_a = speed_clamp(longint'(regs.base_speed_a) + corr, regs.max_speed_a);
            r.speed_b = speed_clamp(longint'(regs.base_speed_b) - corr, regs.max_speed_b);
        end

        hist_prior = hist_last;
        hist_last  = pat;
        return r;
    endfunction

    always @(posedge aclk) begin
        steer_t want;
        if (!aresetn) begin
            // Load register defaults and clear the history, PID state and queue
            regs.gain_p       = RST_GAIN_P;
            regs.gain_i       = RST_GAIN_I;
            regs.gain_d       = RST_GAIN_D;
            regs.setpoint     = RST_SETPOINT;
            regs.base_speed_a = RST_BASE;
            regs.base_speed_b = RST_BASE;
            regs.max_speed_a  = RST_MAX;
            regs.max_speed_b  = RST_MAX;
            hist_last         = '0;
            hist_prior        = '0;
            err_integral      = 0;
            prev_err          = 0;
            pending_steer_q.delete();
        end else begin
            // Track register writes
            if (cfg_wr_en) begin
                case (cfg_wr_index)
                    REG_GAIN_P:       regs.gain_p       = cfg_wr_data;
                    REG_GAIN_I:       regs.gain_i       = cfg_wr_data;
                    REG_GAIN_D:       regs.gain_d       = cfg_wr_data;
                    REG_SETPOINT:     regs.setpoint     = cfg_wr_data[POS_W-1:0];
                    REG_BASE_SPEED_A: regs.base_speed_a = cfg_wr_data[SPEED_W-1:0];
                    REG_BASE_SPEED_B: regs.base_speed_b = cfg_wr_data[SPEED_W-1:0];
                    REG_MAX_SPEED_A:  regs.max_speed_a  = cfg_wr_data[SPEED_W-1:0];
                    REG_MAX_SPEED_B:  regs.max_speed_b  = cfg_wr_data[SPEED_W-1:0];
                    default: ;
                endcase
            end

            // Compare a steering transaction with the oldest command
            if (m_tvalid && m_tready) begin
                if (pending_steer_q.size() == 0) begin
                    $display("%0t: unexpected steering transaction: action %0d speed_a %0d speed_b %0d",
                             $time, m_tuser, m_tdata[7:0], m_tdata[15:8]);
                    errors++;
                end else begin
                    want = pending_steer_q.pop_front();
                    if (m_tuser !== want.action) begin
                        $display("%0t: action mismatch: expected %0d, actual %0d",
                                 $time, want.action, m_tuser);
                        errors++;
                    end
                    if (m_tdata[7:0] !== want.speed_a) begin
                        $display("%0t: speed_a mismatch: expected %0d, actual %0d",
                                 $time, want.speed_a, m_tdata[7:0]);
                        errors++;
                    end
                    if (m_tdata[15:8] !== want.speed_b) begin
                        $display("%0t: speed_b mismatch: expected %0d, actual %0d",
                                 $time, want.speed_b, m_tdata[15:8]);
                        errors++;
                    end
                end
            end

            // Queue the command for an accepted sensor transaction
            if (s_tvalid && s_tready) begin
                pending_steer_q.push_back(compute_steering(s_tdata[PAT_W-1:0],
                                                           s_tdata[PAT_W +: POS_W]));
            end
        end
        fail_count  <= errors;
        outstanding <= pending_steer_q.size();
    end

endmodule

[test/tb_line_follow_steering_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_line_follow_steering_unit
// Drives sensor samples and register settings into the line-follow steering
// unit: a directed pass over the recovery cases and field extremes, a run
// that pushes the integral hard both ways, then random samples under
// several register settings, mostly with random stalls on both channels. A checker
// beside the block scores every steering transaction.
// ----------------------------------------------------------------------------
module tb_line_follow_steering_unit;
    import lfs_pkg::*;

    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 6;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SAT_ITEMS      = 50;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [23:0]           s_tdata;    // [4:0] pattern, [16:5] position
    logic                  m_tvalid;
    logic                  m_tready;
    logic [15:0]           m_tdata;    // [7:0] speed_a, [15:8] speed_b
    logic [1:0]            m_tuser;    // [1:0] action
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_wr_index;
    logic [CFG_DATA_W-1:0] cfg_wr_data;

    logic stall_en;
    int   fail_count;
    int   outstanding;
    int   idle_cycles = 0;

    line_follow_steering_unit dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    lfs_steering_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .fail_count   (fail_count),
        .outstanding  (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // Stall the steering channel in short random bursts
    initial begin
        m_tready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (stall_en && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
        end
    end

    // End the run when no transaction moves for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Offer one sensor sample, with an optional gap first, and hold until taken
    task automatic send_sample(input logic [PAT_W-1:0] pat, input logic [POS_W-1:0] pos);
        if (stall_en && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, pos, pat};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Drop valid and wait until every steering command has come back
    task automatic quiesce();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Write all eight registers on back-to-back cycles
    task automatic write_config(input cfg_t c);
        logic [CFG_DATA_W-1:0] vals [0:7];
        vals[REG_GAIN_P]       = c.gain_p;
        vals[REG_GAIN_I]       = c.gain_i;
        vals[REG_GAIN_D]       = c.gain_d;
        vals[REG_SETPOINT]     = CFG_DATA_W'(c.setpoint);
        vals[REG_BASE_SPEED_A] = CFG_DATA_W'(c.base_speed_a);
        vals[REG_BASE_SPEED_B] = CFG_DATA_W'(c.base_speed_b);
        vals[REG_MAX_SPEED_A]  = CFG_DATA_W'(c.max_speed_a);
        vals[REG_MAX_SPEED_B]  = CFG_DATA_W'(c.max_speed_b);
        for (int i = 0; i < 8; i++) begin
            cfg_wr_en    <= 1'b1;
            cfg_wr_index <= CFG_IDX_W'(i);
            cfg_wr_data  <= vals[i];
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic cfg_t random_config();
        cfg_t c;
        c.gain_p       = GAIN_W'($urandom) >> $urandom_range(0, 15);
        c.gain_i       = GAIN_W'($urandom) >> $urandom_range(0, 15);
        c.gain_d       = GAIN_W'($urandom) >> $urandom_range(0, 15);
        c.setpoint     = POS_W'($urandom);
        c.base_speed_a = SPEED_W'($urandom);
        c.base_speed_b = SPEED_W'($urandom);
        c.max_speed_a  = SPEED_W'($urandom);
        c.max_speed_b  = SPEED_W'($urandom);
        return c;
    endfunction

    // Favor edge, gap and lost-line patterns so recovery paths get exercised
    function automatic logic [PAT_W-1:0] random_pattern();
        logic [PAT_W-1:0] p;
        case ($urandom_range(0, 9))
            0, 1, 2: p = '0;
            3: begin
                case ($urandom_range(0, 2))
                    0: p = 5'b11100;
                    1: p = 5'b11000;
                    default: p = 5'b10000;
                endcase
            end
            4: begin
                case ($urandom_range(0, 2))
                    0: p = 5'b00111;
                    1: p = 5'b00011;
                    default: p = 5'b00001;
                endcase
            end
            5: begin
                case ($urandom_range(0, 2))
                    0: p = 5'b00100;
                    1: p = 5'b00010;
                    default: p = 5'b01000;
                endcase
            end
            default: p = PAT_W'($urandom);
        endcase
        return p;
    endfunction

    function automatic logic [POS_W-1:0] random_position();
        logic [POS_W-1:0] v;
        case ($urandom_range(0, 7))
            0: v = '0;
            1: v = '1;
            2: v = POS_W'($urandom_range(1800, 2200));
            default: v = POS_W'($urandom);
        endcase
        return v;
    endfunction

    task automatic run_random(input int n);
        repeat (n) send_sample(random_pattern(), random_position());
    endtask

    initial begin
        cfg_t c;
        aresetn      <= 1'b0;
        s_tvalid     <= 1'b0;
        s_tdata      <= '0;
        cfg_wr_en    <= 1'b0;
        cfg_wr_index <= '0;
        cfg_wr_data  <= '0;
        stall_en     = 1'b1;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Field extremes and the recovery cases under default settings
        send_sample(5'b11111, 12'd0);
        send_sample(5'b11111, 12'd4095);
        send_sample(5'b01110, 12'd2000);
        send_sample(5'b00000, 12'd1000);   // lost line, no useful history
        send_sample(5'b11100, 12'd2100);
        send_sample(5'b00000, 12'd2100);   // left edge just seen
        send_sample(5'b00000, 12'd2100);   // left edge two samples back
        send_sample(5'b00000, 12'd2100);   // history cleared out
        send_sample(5'b00111, 12'd1900);
        send_sample(5'b00000, 12'd0);      // right edge just seen
        send_sample(5'b11000, 12'd3000);
        send_sample(5'b00011, 12'd3000);
        send_sample(5'b00000, 12'd3000);   // left edge wins over right edge
        send_sample(5'b01010, 12'd2000);
        send_sample(5'b00010, 12'd2000);
        send_sample(5'b00000, 12'd2000);   // line break just seen
        send_sample(5'b00000, 12'd2000);   // line break only two back
        send_sample(5'b01000, 12'd500);
        send_sample(5'b00000, 12'd500);
        send_sample(5'b10000, 12'd4000);
        send_sample(5'b00001, 12'd4000);
        send_sample(5'b00000, 12'd4000);   // both edges in history
        send_sample(5'b00000, 12'd4000);   // right edge two back
        send_sample(5'b00000, 12'd4095);

        // All registers at their maximum
        quiesce();
        c = '1;
        write_config(c);
        run_random(60);

        // Push the integral hard positive, then swing it negative
        quiesce();
        c = random_config();
        c.setpoint = '1;
        write_config(c);
        repeat (SAT_ITEMS) send_sample(PAT_W'($urandom_range(1, 31)), 12'd0);
        quiesce();
        c.setpoint = '0;
        write_config(c);
        repeat (2 * SAT_ITEMS) send_sample(PAT_W'($urandom_range(1, 31)), 12'd4095);
        run_random(20);

        // All registers at zero: every speed pinned to zero
        quiesce();
        c = '0;
        write_config(c);
        run_random(40);

        // Random settings; the last phase runs without stalls
        for (int k = 0; k < 4; k++) begin
            quiesce();
            if (k == 3) stall_en = 1'b0;
            write_config(random_config());
            run_random(80);
        end

        quiesce();
        if (fail_count == 0 && outstanding == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

[line_follow_steering_unit.f]
sv/lfs_pkg.sv
sv/lfs_cfg_regs.sv
sv/line_follow_steering_unit.sv
test/lfs_steering_checker.sv
test/tb_line_follow_steering_unit.sv
